// ===== hw/rtl/bpc_pkg.sv =====
// bpc_pkg: shared types and constants for the button press classifier.
// Holds the configuration register set, lane control word and register indexes.
// No dependencies.
`default_nettype none

package bpc_pkg;

	localparam int unsigned PIN_BITS   = 10;
	localparam int unsigned PLUS_IDX   = 8;
	localparam int unsigned CNT_W      = 8;
	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_THR = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_LONG_THR  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_CEILING   = 2'd2;

	// reset values
	localparam logic [CNT_W-1:0] SHORT_THR_RST = 8'd5;
	localparam logic [CNT_W-1:0] LONG_THR_RST  = 8'd50;
	localparam logic [CNT_W-1:0] CEILING_RST   = 8'd200;

	// input kind codes
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic [CNT_W-1:0] short_thr;
		logic [CNT_W-1:0] long_thr;
		logic [CNT_W-1:0] ceiling;
	} cfg_t;

	typedef struct packed {
		logic tick;
		logic query;
	} lane_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/button_press_classifier_unit.sv =====
// Button press classifier: one lane per button, merged into one result word.
// An accepted word is registered in the output register, or in the skid
// register if the output stalls. Throughput: one word per cycle while s_tready
// is high (low while the skid is full); every lane updates in the accept cycle.
// Reset (arst_n low, asynchronous): counters, flags and marks clear, registers
// return to short 5, long 50, ceiling 200, output empty.
`default_nettype none

module button_press_classifier_unit
	import bpc_pkg::*;
#(
	parameter int unsigned BUTTONS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] raw_pins
	input  wire logic                   s_tuser,   // [0] kind
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // [9:0] pressed_mask, [10] long_press
	input  wire logic                   cfg_we,
	input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [CNT_W-1:0]       cfg_wdata
);

	cfg_t                 cfg_q;
	logic                 accept;
	logic [PIN_BITS-1:0]  pins;
	logic [BUTTONS-1:0]   flags;
	logic [BUTTONS-1:0]   hits;

	assign accept = s_tvalid && s_tready;
	assign pins   = s_tdata[PIN_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_thr <= SHORT_THR_RST;
			cfg_q.long_thr  <= LONG_THR_RST;
			cfg_q.ceiling   <= CEILING_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_SHORT_THR: cfg_q.short_thr <= cfg_wdata;
				CFG_LONG_THR:  cfg_q.long_thr  <= cfg_wdata;
				CFG_CEILING:   cfg_q.ceiling   <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
		lane_ctl_t ctl;
		logic      held;

		assign ctl.tick  = accept && (s_tuser == KIND_TICK);
		// only the plus button answers a long query
		assign ctl.query = (i == PLUS_IDX) && accept && (s_tuser == KIND_QUERY);

		if (i < PIN_BITS) begin : g_pin
			assign held = !pins[i];
		end else begin : g_nopin
			assign held = 1'b0;
		end

		bpc_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg_q),
			.ctl      (ctl),
			.held     (held),
			.flag_d   (flags[i]),
			.long_hit (hits[i])
		);
	end

	bpc_merge #(
		.BUTTONS (BUTTONS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.flags    (flags),
		.long_hit (|hits),
		.in_ready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/bpc_lane.sv =====
// bpc_lane: per-button hold counter, press flag and long mark.
// Depends on bpc_pkg.
`default_nettype none

module bpc_lane
	import bpc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire lane_ctl_t ctl,
	input  wire logic      held,
	output logic           flag_d,
	output logic           long_hit
);

	logic [CNT_W-1:0] count_q;
	logic             flag_q;
	logic             mark_q;
	logic             short_ok;

	assign short_ok = count_q >= cfg.short_thr;
	assign long_hit = ctl.query && (count_q >= cfg.long_thr);

	// flag as it stands after this word; a query leaves it alone
	always_comb begin
		flag_d = flag_q;
		if (ctl.tick) begin
			flag_d = !held && short_ok && !mark_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flag_q  <= 1'b0;
			mark_q  <= 1'b0;
		end else begin
			flag_q <= flag_d;
			if (ctl.tick) begin
				if (held) begin
					if (count_q < cfg.ceiling) begin
						count_q <= count_q + 1'b1;
					end
				end else begin
					if (short_ok) begin
						mark_q <= 1'b0;
					end
					count_q <= '0;
				end
			end else if (long_hit) begin
				count_q <= '0;
				mark_q  <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bpc_merge.sv =====
// bpc_merge: gathers lane flags into the result word and holds it in an
// output register backed by a skid register. Depends on bpc_pkg.
`default_nettype none

module bpc_merge
	import bpc_pkg::*;
#(
	parameter int unsigned BUTTONS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire logic [BUTTONS-1:0]     flags,
	input  wire logic                   long_hit,
	output logic                        in_ready,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	localparam int unsigned RES_W = PIN_BITS + 1;

	logic [PIN_BITS-1:0]    mask;
	logic [RES_W-1:0]       res;
	logic [RES_W-1:0]       out_q;
	logic [RES_W-1:0]       skid_q;
	logic                   out_vld_q;
	logic                   skid_vld_q;
	logic                   pop;

	for (genvar i = 0; i < PIN_BITS; i++) begin : g_mask
		if (i < BUTTONS) begin : g_on
			assign mask[i] = flags[i];
		end else begin : g_off
			assign mask[i] = 1'b0;
		end
	end

	assign res      = {long_hit, mask};
	assign pop      = out_vld_q && m_tready;
	assign in_ready = !skid_vld_q;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= accept;
			end
		end else if (accept) begin
			if (out_vld_q) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end
	end

	// payload: move skid forward on pop, else land new word where there is room
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			if (out_vld_q) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bpc_checker.sv =====
// bpc_checker: port-level checks on the button press classifier and the
// bind that attaches them to the top level. Depends on bpc_pkg.
`default_nettype none

module bpc_checker
	import bpc_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// an accepted word always leaves a result waiting
	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted word produced no result");

	// input back-pressure only while the output register is full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:PIN_BITS+1] == '0)
		else $error("result padding not zero");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
